/* src/tlrq_pkg.sv */
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types and constants of the two-level ready queue.
// ----------------------------------------------------------------------------
package tlrq_pkg;

  // Thread identifier width and default ring depth
  localparam int unsigned IdW            = 6;
  localparam int unsigned MaxThreadsDflt = 64;

  // Item layout on the slave side: command, thread_id, assigned_is_io, effective_is_io
  localparam int unsigned CmdW     = 2;
  localparam int unsigned InDataW  = 16;
  // Item layout on the master side: got_thread, next_thread, from_io_level, insert_dropped
  localparam int unsigned OutFldW  = 1 + IdW + 1 + 1;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_TAIL = 2'd0,
    CMD_ADD_HEAD = 2'd1,
    CMD_DEQUEUE  = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  // Request to one ring for the current item
  typedef struct packed {
    logic ins;
    logic at_head;
    logic pop;
  } ring_cmd_t;

  // Occupancy status of one ring
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

/* src/tlrq_ring.sv */
// ----------------------------------------------------------------------------
// tlrq_ring
// One double-ended ring of thread identifiers: a synchronous memory plus a
// head pointer and an occupancy count. Pop data is registered, ready in the
// cycle after the pop.
// ----------------------------------------------------------------------------
module tlrq_ring #(
  parameter int unsigned Depth = tlrq_pkg::MaxThreadsDflt
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tlrq_pkg::ring_cmd_t      cmd_i,
  input  logic [tlrq_pkg::IdW-1:0] id_i,
  output tlrq_pkg::ring_stat_t     stat_o,
  output logic [tlrq_pkg::IdW-1:0] rd_data_o
);
  import tlrq_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = CntW + 1;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [SumW-1:0] DepthS  = SumW'(Depth);

  logic [IdW-1:0]  mem_q [Depth];
  logic [IdW-1:0]  rd_data_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail_idx;
  logic [IdxW-1:0] head_dec;
  logic [IdxW-1:0] head_inc;
  logic [IdxW-1:0] wr_addr;

  // Ring index arithmetic, wrapped once modulo the depth
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    tail_idx = (tail_sum >= DepthS) ? IdxW'(tail_sum - DepthS) : IdxW'(tail_sum);
    head_dec = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
    head_inc = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
    wr_addr  = cmd_i.at_head ? head_dec : tail_idx;
  end

  // Advance head and count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.ins) begin
      if (cmd_i.at_head) begin
        head_d = head_dec;
      end
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Write on insert, read the head on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      mem_q[wr_addr] <= id_i;
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);
  assign rd_data_o    = rd_data_q;

endmodule

/* src/two_level_ready_queue.sv */
// ----------------------------------------------------------------------------
// two_level_ready_queue
// Strict-priority ready queue of thread identifiers with an I/O ring and a
// normal ring.
// ----------------------------------------------------------------------------
// Each item is one command: add a thread at the tail or head of its level's
// ring (I/O when either priority flag is set), or dequeue the next ready
// thread, I/O ring first. Every item yields exactly one result item. An
// accepted item waits in the in-flight stage, where the ring memory's read
// is registered, and moves to the output register once that register is free
// or being taken. A new item is accepted only while no item is in flight;
// one finished result may wait on the master side while the next item is in
// flight. An add to a full ring is dropped and flagged in insert_dropped.
// ----------------------------------------------------------------------------
module two_level_ready_queue #(
  parameter int unsigned MaxThreads = tlrq_pkg::MaxThreadsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] command, [7:2] thread_id, [8] assigned_is_io, [9] effective_is_io
  input  logic [tlrq_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] got_thread, [6:1] next_thread, [7] from_io_level, [8] insert_dropped
  output logic [tlrq_pkg::OutDataW-1:0] m_axis_tdata
);
  import tlrq_pkg::*;

  cmd_e           cmd;
  logic [IdW-1:0] in_id;
  logic           in_is_io;
  logic           accept;
  logic           is_add;
  logic           is_deq;

  ring_cmd_t      io_cmd, nrm_cmd;
  ring_stat_t     io_stat, nrm_stat;
  logic [IdW-1:0] io_rd, nrm_rd;

  logic           p_valid_q, p_valid_d;
  logic           p_got_q, p_from_io_q, p_drop_q;
  logic           move;
  logic [IdW-1:0] p_thread;

  logic               out_valid_q, out_valid_d;
  logic [OutFldW-1:0] out_data_q;

  // Decode the incoming item
  always_comb begin
    cmd      = cmd_e'(s_axis_tdata[CmdW-1:0]);
    in_id    = s_axis_tdata[CmdW +: IdW];
    in_is_io = s_axis_tdata[CmdW + IdW] | s_axis_tdata[CmdW + IdW + 1];
    is_add   = (cmd == CMD_ADD_TAIL) || (cmd == CMD_ADD_HEAD);
    is_deq   = (cmd == CMD_DEQUEUE);
  end

  assign s_axis_tready = !p_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Steer the command to at most one ring
  always_comb begin
    io_cmd.ins      = accept && is_add && in_is_io && !io_stat.full;
    io_cmd.at_head  = (cmd == CMD_ADD_HEAD);
    io_cmd.pop      = accept && is_deq && !io_stat.empty;
    nrm_cmd.ins     = accept && is_add && !in_is_io && !nrm_stat.full;
    nrm_cmd.at_head = (cmd == CMD_ADD_HEAD);
    nrm_cmd.pop     = accept && is_deq && io_stat.empty && !nrm_stat.empty;
  end

  tlrq_ring #(.Depth(MaxThreads)) u_io_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (io_cmd),
    .id_i      (in_id),
    .stat_o    (io_stat),
    .rd_data_o (io_rd)
  );

  tlrq_ring #(.Depth(MaxThreads)) u_nrm_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (nrm_cmd),
    .id_i      (in_id),
    .stat_o    (nrm_stat),
    .rd_data_o (nrm_rd)
  );

  // Hold the in-flight item until the output register frees up
  assign move        = p_valid_q && (!out_valid_q || m_axis_tready);
  assign p_valid_d   = accept || (p_valid_q && !move);
  assign out_valid_d = move || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_got_q     <= io_cmd.pop || nrm_cmd.pop;
      p_from_io_q <= io_cmd.pop;
      p_drop_q    <= is_add && (in_is_io ? io_stat.full : nrm_stat.full);
    end
  end

  // Select the popped identifier once the memory read has landed
  always_comb begin
    if (!p_got_q) begin
      p_thread = '0;
    end else if (p_from_io_q) begin
      p_thread = io_rd;
    end else begin
      p_thread = nrm_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_data_q <= {p_drop_q, p_from_io_q, p_thread, p_got_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutFldW)'(0), out_data_q};

endmodule
